// ===== hdl/integer_to_ascii_formatter_macros.svh =====
// Assertion macros for the integer-to-ASCII formatter checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define I2A_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2a check failed");

// Next-cycle implication, disabled during reset.
`define I2A_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2a check failed");

`endif

// ===== hdl/i2a_pkg.sv =====
// Shared types, codes and constants of the integer-to-ASCII formatter.
// No dependencies.
`default_nettype none

package i2a_pkg;

    // Conversion modes carried in the func field
    localparam logic [2:0] FUNC_BIN64  = 3'd0;
    localparam logic [2:0] FUNC_UDEC64 = 3'd1;
    localparam logic [2:0] FUNC_SDEC64 = 3'd2;
    localparam logic [2:0] FUNC_HEX64  = 3'd3;
    localparam logic [2:0] FUNC_SDEC32 = 3'd4;
    localparam logic [2:0] FUNC_HEX32  = 3'd5;

    // Lead codes on the first character of a value
    localparam logic [1:0] LEAD_NONE  = 2'd0;
    localparam logic [1:0] LEAD_MINUS = 2'd1;
    localparam logic [1:0] LEAD_HEX   = 2'd2;
    localparam logic [1:0] LEAD_BIN   = 2'd3;

    // Digit register: 20 BCD digits cover any 64-bit magnitude
    localparam int DEC_DIGITS = 20;
    localparam int EMIT_W     = 4 * DEC_DIGITS;
    localparam int COUNT_W    = 7;

    localparam logic [COUNT_W-1:0] COUNT_BIN64 = 7'd64;
    localparam logic [COUNT_W-1:0] COUNT_HEX64 = 7'd16;
    localparam logic [COUNT_W-1:0] COUNT_HEX32 = 7'd8;
    localparam logic [COUNT_W-1:0] COUNT_DEC   = 7'd20;

    // ASCII digit set, lowercase hex
    localparam logic [7:0] DIGIT_SET [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] value;
    } item_t;

    typedef struct packed {
        logic [7:0] digit_char;
        logic [1:0] lead_code;
        logic       last;
    } char_t;

    typedef enum logic [1:0] {
        RADIX_BIN,
        RADIX_DEC,
        RADIX_HEX
    } radix_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic dabble;
        logic skip;
        logic emit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic func_ok;
        logic func_dec;
        logic iter_last;
        logic top_zero;
        logic count_one;
        logic out_space;
    } status_t;

endpackage

`default_nettype wire

// ===== hdl/integer_to_ascii_formatter.sv =====
// Top level of the integer-to-ASCII formatter: controller plus datapath.
// Uses i2a_pkg, i2a_ctrl and i2a_dpath.
`default_nettype none

// Takes one item (mode and 64-bit value) and sends its digits as characters,
// most significant first, one character per transfer; the sign or radix
// prefix rides as lead_code on the first character and the last character
// is flagged. Items with mode 6 or 7 are taken and produce nothing. One item
// is worked at a time and item_stall stays high until its last character
// has entered the output register. Decimal modes run a shift-add-3 BCD
// conversion, one bit per cycle; every mode then suppresses leading zeros,
// keeping at least one digit, and sends the remaining digits, holding while
// the output side stalls.
module integer_to_ascii_formatter
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    output logic                item_stall,
    input  wire i2a_pkg::item_t item_data,
    output logic                char_valid,
    input  wire logic           char_stall,
    output i2a_pkg::char_t      char_data
);

    i2a_pkg::cmd_t    cmd;
    i2a_pkg::status_t status;

    i2a_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .status     (status),
        .cmd        (cmd),
        .item_stall (item_stall)
    );

    i2a_dpath u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_data  (item_data),
        .cmd        (cmd),
        .char_stall (char_stall),
        .status     (status),
        .char_valid (char_valid),
        .char_data  (char_data)
    );

endmodule

`default_nettype wire

// ===== hdl/i2a_ctrl.sv =====
// Sequencer of the integer-to-ASCII formatter: load, BCD conversion,
// leading-zero skip and character emission. Uses i2a_pkg.
`default_nettype none

module i2a_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    input  wire i2a_pkg::status_t status,
    output i2a_pkg::cmd_t         cmd,
    output logic                  item_stall
);

    i2a_pkg::state_t state_reg;
    i2a_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= i2a_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_stall = 1'b1;
        case (state_reg)
            i2a_pkg::ST_IDLE:
            begin
                item_stall = 1'b0;
                // drop items with an undefined mode
                if (item_valid && status.func_ok)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.func_dec ? i2a_pkg::ST_CONVERT : i2a_pkg::ST_SKIP;
                end
            end
            i2a_pkg::ST_CONVERT:
            begin
                cmd.dabble = 1'b1;
                if (status.iter_last)
                begin
                    state_next = i2a_pkg::ST_SKIP;
                end
            end
            i2a_pkg::ST_SKIP:
            begin
                if (status.top_zero && !status.count_one)
                begin
                    cmd.skip = 1'b1;
                end
                else
                begin
                    state_next = i2a_pkg::ST_EMIT;
                end
            end
            i2a_pkg::ST_EMIT:
            begin
                if (status.out_space)
                begin
                    cmd.emit = 1'b1;
                    if (status.count_one)
                    begin
                        state_next = i2a_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = i2a_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/i2a_dpath.sv =====
// Datapath of the integer-to-ASCII formatter: magnitude, shift-add-3 BCD
// converter, digit register and output register. Uses i2a_pkg.
`default_nettype none

module i2a_dpath
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire i2a_pkg::item_t   item_data,
    input  wire i2a_pkg::cmd_t    cmd,
    input  wire logic             char_stall,
    output i2a_pkg::status_t      status,
    output logic                  char_valid,
    output i2a_pkg::char_t        char_data
);

    logic [63:0]                   bin_reg;
    logic [63:0]                   bin_next;
    logic [i2a_pkg::EMIT_W-1:0]    emit_reg;
    logic [i2a_pkg::EMIT_W-1:0]    emit_next;
    logic [5:0]                    iter_reg;
    logic [5:0]                    iter_next;
    logic [i2a_pkg::COUNT_W-1:0]   count_reg;
    logic [i2a_pkg::COUNT_W-1:0]   count_next;
    i2a_pkg::radix_t               radix_reg;
    i2a_pkg::radix_t               radix_next;
    logic [1:0]                    lead_reg;
    logic [1:0]                    lead_next;
    logic                          first_reg;
    logic                          first_next;
    logic                          char_valid_reg;
    logic                          char_valid_next;
    i2a_pkg::char_t                char_reg;
    i2a_pkg::char_t                char_next;

    logic [31:0]                   low_word;
    logic [i2a_pkg::EMIT_W-1:0]    bcd_adj;
    logic [i2a_pkg::EMIT_W-1:0]    emit_shifted;
    logic [3:0]                    top_nib;

    assign low_word = item_data.value[31:0];

    // Add 3 to every BCD digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < i2a_pkg::DEC_DIGITS; i++)
        begin
            bcd_adj[4*i +: 4] = (emit_reg[4*i +: 4] >= 4'd5) ?
                                emit_reg[4*i +: 4] + 4'd3 : emit_reg[4*i +: 4];
        end
    end

    // Top digit and the register advanced by one digit
    always_comb
    begin
        if (radix_reg == i2a_pkg::RADIX_BIN)
        begin
            top_nib      = {3'b000, emit_reg[i2a_pkg::EMIT_W-1]};
            emit_shifted = {emit_reg[i2a_pkg::EMIT_W-2:0], 1'b0};
        end
        else
        begin
            top_nib      = emit_reg[i2a_pkg::EMIT_W-1 -: 4];
            emit_shifted = {emit_reg[i2a_pkg::EMIT_W-5:0], 4'h0};
        end
    end

    // Status toward the controller
    always_comb
    begin
        status.func_ok   = (item_data.func <= i2a_pkg::FUNC_HEX32);
        status.func_dec  = item_data.func inside {i2a_pkg::FUNC_UDEC64,
                                                  i2a_pkg::FUNC_SDEC64,
                                                  i2a_pkg::FUNC_SDEC32};
        status.iter_last = (iter_reg == 6'd63);
        status.top_zero  = (top_nib == 4'h0);
        status.count_one = (count_reg == 7'd1);
        status.out_space = !char_valid_reg || !char_stall;
    end

    // Next values of the datapath registers
    always_comb
    begin
        bin_next        = bin_reg;
        emit_next       = emit_reg;
        iter_next       = iter_reg;
        count_next      = count_reg;
        radix_next      = radix_reg;
        lead_next       = lead_reg;
        first_next      = first_reg;
        char_next       = char_reg;
        char_valid_next = char_valid_reg;

        // drop the held character once transferred
        if (char_valid_reg && !char_stall)
        begin
            char_valid_next = 1'b0;
        end

        if (cmd.load)
        begin
            iter_next  = '0;
            first_next = 1'b1;
            bin_next   = item_data.value;
            emit_next  = '0;
            radix_next = i2a_pkg::RADIX_DEC;
            lead_next  = i2a_pkg::LEAD_NONE;
            count_next = i2a_pkg::COUNT_DEC;
            case (item_data.func)
                i2a_pkg::FUNC_BIN64:
                begin
                    radix_next = i2a_pkg::RADIX_BIN;
                    lead_next  = i2a_pkg::LEAD_BIN;
                    emit_next  = {item_data.value, 16'h0000};
                    count_next = i2a_pkg::COUNT_BIN64;
                end
                i2a_pkg::FUNC_SDEC64:
                begin
                    if (item_data.value[63])
                    begin
                        bin_next  = ~item_data.value + 64'd1;
                        lead_next = i2a_pkg::LEAD_MINUS;
                    end
                end
                i2a_pkg::FUNC_HEX64:
                begin
                    radix_next = i2a_pkg::RADIX_HEX;
                    lead_next  = i2a_pkg::LEAD_HEX;
                    emit_next  = {item_data.value, 16'h0000};
                    count_next = i2a_pkg::COUNT_HEX64;
                end
                i2a_pkg::FUNC_SDEC32:
                begin
                    if (low_word[31])
                    begin
                        bin_next  = {32'h0, ~low_word + 32'd1};
                        lead_next = i2a_pkg::LEAD_MINUS;
                    end
                    else
                    begin
                        bin_next = {32'h0, low_word};
                    end
                end
                i2a_pkg::FUNC_HEX32:
                begin
                    radix_next = i2a_pkg::RADIX_HEX;
                    lead_next  = i2a_pkg::LEAD_HEX;
                    emit_next  = {low_word, 48'h0};
                    count_next = i2a_pkg::COUNT_HEX32;
                end
                default:
                begin
                    // unsigned decimal keeps the defaults above
                end
            endcase
        end
        else if (cmd.dabble)
        begin
            // shift one binary bit into the BCD register
            emit_next = {bcd_adj[i2a_pkg::EMIT_W-2:0], bin_reg[63]};
            bin_next  = {bin_reg[62:0], 1'b0};
            iter_next = iter_reg + 6'd1;
        end
        else if (cmd.skip)
        begin
            emit_next  = emit_shifted;
            count_next = count_reg - 7'd1;
        end
        else if (cmd.emit)
        begin
            char_next.digit_char = i2a_pkg::DIGIT_SET[top_nib];
            char_next.lead_code  = first_reg ? lead_reg : i2a_pkg::LEAD_NONE;
            char_next.last       = (count_reg == 7'd1);
            char_valid_next      = 1'b1;
            emit_next            = emit_shifted;
            count_next           = count_reg - 7'd1;
            first_next           = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg <= 1'b0;
            iter_reg       <= '0;
            count_reg      <= '0;
            first_reg      <= 1'b0;
            radix_reg      <= i2a_pkg::RADIX_DEC;
        end
        else
        begin
            char_valid_reg <= char_valid_next;
            iter_reg       <= iter_next;
            count_reg      <= count_next;
            first_reg      <= first_next;
            radix_reg      <= radix_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        emit_reg <= emit_next;
        lead_reg <= lead_next;
        char_reg <= char_next;
    end

    assign char_valid = char_valid_reg;
    assign char_data  = char_reg;

endmodule

`default_nettype wire

// ===== hdl/i2a_checker.sv =====
// Port-level checks of the integer-to-ASCII formatter, bound to the top.
// Uses i2a_pkg and integer_to_ascii_formatter_macros.svh.
`default_nettype none

`include "integer_to_ascii_formatter_macros.svh"

module i2a_checker
(
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           item_valid,
    input wire logic           item_stall,
    input wire i2a_pkg::item_t item_data,
    input wire logic           char_valid,
    input wire logic           char_stall,
    input wire i2a_pkg::char_t char_data
);

    logic mid_reg;
    logic item_xfer;
    logic char_xfer;

    assign item_xfer = item_valid && !item_stall;
    assign char_xfer = char_valid && !char_stall;

    // Track whether the next character continues a value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg <= 1'b0;
        end
        else if (char_xfer)
        begin
            mid_reg <= !char_data.last;
        end
    end

    // A stalled character holds
    `I2A_ASSERT_NEXT(a_char_hold, char_valid && char_stall, char_valid && $stable(char_data))

    // A taken item with a defined mode blocks the next item
    `I2A_ASSERT_NEXT(a_item_busy, item_xfer && (item_data.func <= i2a_pkg::FUNC_HEX32), item_stall)

    // Only the first character of a value carries a lead code
    `I2A_ASSERT_IMPL(a_lead_first, char_valid && mid_reg, char_data.lead_code == i2a_pkg::LEAD_NONE)

    // A value of several digits never opens with a zero
    `I2A_ASSERT_IMPL(a_no_lead_zero, char_valid && !mid_reg && !char_data.last, char_data.digit_char != 8'h30)

endmodule

bind integer_to_ascii_formatter i2a_checker u_i2a_checker (.*);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the integer-to-ASCII formatter.
// Queues directed and random items, predicts each character and checks the
// output stream in order. Depends on i2a_pkg and integer_to_ascii_formatter.

module testbench;

    // Modes the block takes and drops without output
    localparam logic [2:0] FUNC_RSVD_A = 3'd6;
    localparam logic [2:0] FUNC_RSVD_B = 3'd7;

    localparam logic [63:0] BASE_BIN = 64'd2;
    localparam logic [63:0] BASE_DEC = 64'd10;
    localparam logic [63:0] BASE_HEX = 64'd16;

    localparam int MAX_CHARS      = 64;
    localparam int RANDOM_ITEMS   = 340;
    localparam int BLOCK_ITEMS    = 40;
    localparam int HOLDOFF_AT     = 1000;
    localparam int HOLDOFF_CYCLES = 600;
    localparam int SETTLE_CYCLES  = 200;
    localparam int CYCLE_LIMIT    = 10000000;

    typedef struct {
        i2a_pkg::item_t item;
        bit             drain_first;
        bit             steady;
    } pending_t;

    logic            clk        = 1'b0;
    logic            rst_n      = 1'b0;
    logic            item_valid = 1'b0;
    logic            item_stall;
    i2a_pkg::item_t  item_data  = '0;
    logic            char_valid;
    logic            char_stall = 1'b0;
    i2a_pkg::char_t  char_data;

    pending_t       pending_items [$];
    i2a_pkg::char_t expected_chars [$];
    int             failures     = 0;
    int             gap_left     = 0;
    int             chars_seen   = 0;
    int             stall_left   = 0;
    int             run_left     = 0;
    bit             holdoff_done = 1'b0;

    integer_to_ascii_formatter dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_data  (item_data),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Work out the characters one item produces and append them in order
    function automatic void predict_chars(i2a_pkg::item_t it);
        logic [63:0]    mag;
        logic [63:0]    base;
        logic [63:0]    rem;
        logic [31:0]    low_word;
        logic [1:0]     lead;
        logic [7:0]     rev [MAX_CHARS];
        i2a_pkg::char_t c;
        int             n;
        low_word = it.value[31:0];
        case (it.func)
            i2a_pkg::FUNC_BIN64:
            begin
                mag = it.value; base = BASE_BIN; lead = i2a_pkg::LEAD_BIN;
            end
            i2a_pkg::FUNC_UDEC64:
            begin
                mag = it.value; base = BASE_DEC; lead = i2a_pkg::LEAD_NONE;
            end
            i2a_pkg::FUNC_SDEC64:
            begin
                base = BASE_DEC;
                if (it.value[63])
                begin
                    mag = ~it.value + 64'd1; lead = i2a_pkg::LEAD_MINUS;
                end
                else
                begin
                    mag = it.value; lead = i2a_pkg::LEAD_NONE;
                end
            end
            i2a_pkg::FUNC_HEX64:
            begin
                mag = it.value; base = BASE_HEX; lead = i2a_pkg::LEAD_HEX;
            end
            i2a_pkg::FUNC_SDEC32:
            begin
                base = BASE_DEC;
                if (low_word[31])
                begin
                    mag = {32'd0, ~low_word + 32'd1}; lead = i2a_pkg::LEAD_MINUS;
                end
                else
                begin
                    mag = {32'd0, low_word}; lead = i2a_pkg::LEAD_NONE;
                end
            end
            i2a_pkg::FUNC_HEX32:
            begin
                mag = {32'd0, low_word}; base = BASE_HEX; lead = i2a_pkg::LEAD_HEX;
            end
            default:
                return;
        endcase
        // Peel digits off the low end, then emit them most significant first
        n = 0;
        do
        begin
            rem = mag % base;
            rev[n] = i2a_pkg::DIGIT_SET[rem[3:0]];
            mag = mag / base;
            n++;
        end
        while (mag != 64'd0 && n < MAX_CHARS);
        for (int k = 0; k < n; k++)
        begin
            c.digit_char = rev[n - 1 - k];
            c.lead_code  = (k == 0) ? lead : i2a_pkg::LEAD_NONE;
            c.last       = (k == n - 1);
            expected_chars.push_back(c);
        end
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 90);
    endfunction

    // Values shaped to hit short and long digit strings and sign boundaries
    function automatic logic [63:0] random_value();
        logic [63:0] v;
        int unsigned shape;
        v = {$urandom(), $urandom()};
        shape = $urandom_range(0, 9);
        case (shape)
            0: v = v >> $urandom_range(1, 63);
            1: v = 64'd1 << $urandom_range(0, 63);
            2: v = v & 64'hFF;
            3: v = ~64'd0 >> $urandom_range(0, 63);
            4: v = 64'd0 - (v & 64'hFFFF);
            5: v = {v[63:32], 32'd0 - (v[31:0] & 32'hFFF)};
            6: v = {v[63:32], 32'd0 + (v[31:0] >> $urandom_range(1, 31))};
            default: ;
        endcase
        return v;
    endfunction

    task automatic queue_item(logic [2:0] func, logic [63:0] value, bit drain, bit steady);
        pending_t p;
        p.item.func  = func;
        p.item.value = value;
        p.drain_first = drain;
        p.steady      = steady;
        pending_items.push_back(p);
    endtask

    // Driver: present queued items, predict each one on its transfer
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        logic     offer;
        pending_t p;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item_data  <= '0;
            gap_left   <= 0;
        end
        else
        begin
            offer = item_valid;
            if (item_valid && !item_stall)
            begin
                predict_chars(item_data);
                offer = 1'b0;
            end
            if (!offer)
            begin
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else if (pending_items.size() > 0 &&
                         !(pending_items[0].drain_first && expected_chars.size() != 0))
                begin
                    p = pending_items.pop_front();
                    item_data <= p.item;
                    offer = 1'b1;
                    gap_left <= p.steady ? 0 : pick_gap();
                end
            end
            item_valid <= offer;
        end
    end

    // Monitor: check each character transfer, drive the output stall pattern
    always @(posedge clk or negedge rst_n)
    begin : check_chars
        i2a_pkg::char_t want;
        logic           stall_now;
        if (!rst_n)
        begin
            char_stall <= 1'b0;
        end
        else
        begin
            if (char_valid && !char_stall)
            begin
                chars_seen++;
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected character: digit_char %h lead_code %0d last %0b",
                           char_data.digit_char, char_data.lead_code, char_data.last);
                    failures++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (char_data.digit_char !== want.digit_char)
                    begin
                        $error("digit_char: expected %h, actual %h",
                               want.digit_char, char_data.digit_char);
                        failures++;
                    end
                    if (char_data.lead_code !== want.lead_code)
                    begin
                        $error("lead_code: expected %0d, actual %0d",
                               want.lead_code, char_data.lead_code);
                        failures++;
                    end
                    if (char_data.last !== want.last)
                    begin
                        $error("last: expected %0b, actual %0b", want.last, char_data.last);
                        failures++;
                    end
                end
            end
            // Hold off once for a long stretch so the input side backs up
            if (!holdoff_done && chars_seen >= HOLDOFF_AT)
            begin
                holdoff_done = 1'b1;
                stall_left = HOLDOFF_CYCLES;
                run_left = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                stall_now = 1'b1;
            end
            else if (run_left > 0)
            begin
                run_left--;
                stall_now = 1'b0;
            end
            else
            begin
                // Start a new burst: a stall, then a run of ready cycles
                stall_now = 1'b0;
                run_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                       : $urandom_range(1, 12);
                stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3)
                                                          : $urandom_range(10, 40);
            end
            char_stall <= stall_now;
        end
    end

    // Cycle watchdog
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    // Stimulus and end of run
    initial
    begin : stimulus
        int          counted;
        int          in_block;
        bit          steady;
        bit          drain;
        logic [2:0]  func;
        // Directed: extremes, every mode, zero, most negative, dropped modes
        queue_item(i2a_pkg::FUNC_BIN64,  64'd0, 1'b1, 1'b0);
        queue_item(i2a_pkg::FUNC_BIN64,  64'd1, 1'b0, 1'b0);
        queue_item(i2a_pkg::FUNC_BIN64,  ~64'd0, 1'b0, 1'b0);
        queue_item(i2a_pkg::FUNC_BIN64,  64'h8000_0000_0000_0000, 1'b0, 1'b0);
        queue_item(i2a_pkg::FUNC_UDEC64, 64'd0, 1'b0, 1'b0);
        queue_item(i2a_pkg::FUNC_UDEC64, ~64'd0, 1'b0, 1'b0);
        queue_item(i2a_pkg::FUNC_UDEC64, 64'd9, 1'b0, 1'b0);
        queue_item(i2a_pkg::FUNC_UDEC64, 64'd10, 1'b0, 1'b0);
        queue_item(i2a_pkg::FUNC_SDEC64, 64'd0, 1'b0, 1'b0);
        queue_item(i2a_pkg::FUNC_SDEC64, 64'h8000_0000_0000_0000, 1'b0, 1'b0);
        queue_item(i2a_pkg::FUNC_SDEC64, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
        queue_item(i2a_pkg::FUNC_SDEC64, ~64'd0, 1'b0, 1'b0);
        queue_item(i2a_pkg::FUNC_HEX64,  64'd0, 1'b0, 1'b0);
        queue_item(i2a_pkg::FUNC_HEX64,  ~64'd0, 1'b0, 1'b0);
        queue_item(i2a_pkg::FUNC_HEX64,  64'h0123_4567_89AB_CDEF, 1'b0, 1'b0);
        queue_item(i2a_pkg::FUNC_SDEC32, 64'd0, 1'b0, 1'b0);
        queue_item(i2a_pkg::FUNC_SDEC32, 64'hFFFF_FFFF_8000_0000, 1'b0, 1'b0);
        queue_item(i2a_pkg::FUNC_SDEC32, 64'h0000_0000_7FFF_FFFF, 1'b0, 1'b0);
        queue_item(i2a_pkg::FUNC_SDEC32, 64'hAAAA_AAAA_FFFF_FFFF, 1'b0, 1'b0);
        queue_item(i2a_pkg::FUNC_HEX32,  64'd0, 1'b0, 1'b0);
        queue_item(i2a_pkg::FUNC_HEX32,  64'h1234_5678_FFFF_FFFF, 1'b0, 1'b0);
        queue_item(i2a_pkg::FUNC_HEX32,  64'hFFFF_FFFF_0000_0000, 1'b0, 1'b0);
        queue_item(FUNC_RSVD_A, ~64'd0, 1'b0, 1'b0);
        queue_item(FUNC_RSVD_B, 64'h5555_5555_5555_5555, 1'b0, 1'b0);
        queue_item(i2a_pkg::FUNC_HEX32,  64'h0000_0000_DEAD_BEEF, 1'b0, 1'b0);

        // Random: blocks of items, some without gaps, some after a full drain
        counted = 0;
        in_block = 0;
        steady = 1'b0;
        while (counted < RANDOM_ITEMS)
        begin
            drain = 1'b0;
            if (in_block == 0)
            begin
                steady = ($urandom_range(0, 3) == 0);
                drain = (counted == 0) || ($urandom_range(0, 2) == 0);
            end
            if ($urandom_range(0, 19) == 0)
                func = $urandom_range(0, 1) ? FUNC_RSVD_A : FUNC_RSVD_B;
            else
            begin
                func = 3'($urandom_range(i2a_pkg::FUNC_BIN64, i2a_pkg::FUNC_HEX32));
                counted++;
                in_block = (in_block + 1) % BLOCK_ITEMS;
            end
            queue_item(func, random_value(), drain, steady);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Wait out all transfers and expected characters, then settle
        while (pending_items.size() != 0 || item_valid)
            @(posedge clk);
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0 && expected_chars.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/i2a_pkg.sv
hdl/i2a_ctrl.sv
hdl/i2a_dpath.sv
hdl/integer_to_ascii_formatter.sv
hdl/i2a_checker.sv
tb/sv/testbench.sv
